/* hdl/apc_pkg.sv */
// Shared constants for the amicable pair checker.
package apc_pkg;

    localparam int VALUE_BITS_DEF = 16;
    // Headroom bits for the divisor sum; sigma(n) < 8n over the supported range.
    localparam int SUM_EXTRA      = 3;

endpackage

/* hdl/amicable_pair_check.sv */
// Amicable pair checker: top level with trial-division sequencer.
//
//  channel | dir | word contents
//  s_axis  | in  | first_value, second_value
//  m_axis  | out | is_pair
//
// Each value takes floor(sqrt(v))+1 trial divisions on the shared divider; a word needs
// the sum of both. A word with either value below two skips the divisions.
// Reset is synchronous, active low; it clears the sequencer and output valid.
// Input is taken only when idle; a finished result waits in the output register,
// and the next word may be accepted while it stalls.
module amicable_pair_check
    import apc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_W      = ((2 * VALUE_BITS + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,   // first_value, second_value
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata    // is_pair
);

    localparam int SUM_W = VALUE_BITS + SUM_EXTRA;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_a, n_a, r_b, n_b, r_d, n_d;
    logic                  r_sel, n_sel;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic                  r_hit, n_hit;
    logic                  r_ovalid, n_ovalid;
    logic                  r_odata, n_odata;

    logic                  div_start, div_done;
    logic [VALUE_BITS-1:0] div_quo, div_rem, cur, oth;
    logic [SUM_W-1:0]      proper;
    logic [VALUE_BITS-1:0] in_a, in_b;

    assign in_a = i_s_tdata[VALUE_BITS-1:0];
    assign in_b = i_s_tdata[2*VALUE_BITS-1:VALUE_BITS];

    assign cur    = r_sel ? r_b : r_a;
    assign oth    = r_sel ? r_a : r_b;
    assign proper = r_sum - SUM_W'(cur);

    assign div_start = (r_state == ST_START);

    apc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_d      = r_d;
        n_sel    = r_sel;
        n_sum    = r_sum;
        n_hit    = r_hit;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_a   = in_a;
                    n_b   = in_b;
                    n_sel = 1'b0;
                    n_d   = VALUE_BITS'(1);
                    n_sum = '0;
                    n_hit = 1'b0;
                    if (in_a < VALUE_BITS'(2) || in_b < VALUE_BITS'(2)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (div_quo < r_d) begin
                        // passed sqrt(v): this value's sum is complete
                        n_d   = VALUE_BITS'(1);
                        n_sum = '0;
                        if (!r_sel) begin
                            n_hit   = (proper == SUM_W'(oth));
                            n_sel   = 1'b1;
                            n_state = ST_START;
                        end else begin
                            n_hit   = r_hit && (proper == SUM_W'(oth));
                            n_state = ST_FIN;
                        end
                    end else begin
                        if (div_rem == '0) begin
                            n_sum = r_sum + SUM_W'(r_d)
                                  + ((div_quo != r_d) ? SUM_W'(div_quo) : '0);
                        end
                        n_d     = r_d + 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            ST_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_hit;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_d     <= n_d;
        r_sel   <= n_sel;
        r_sum   <= n_sum;
        r_hit   <= n_hit;
        r_odata <= n_odata;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_odata};

endmodule

/* hdl/apc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all trial divisions.
module apc_div
    import apc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quo,
    output logic [VALUE_BITS-1:0] o_rem
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [VALUE_BITS:0]   r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_dsr, n_dsr;
    logic                  r_done, n_done;
    logic [VALUE_BITS:0]   trial;
    logic                  fits;

    assign trial = {r_rem[VALUE_BITS-1:0], r_quo[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? (trial - {1'b0, r_dsr}) : trial;
            n_quo = {r_quo[VALUE_BITS-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[VALUE_BITS-1:0];

endmodule

/* hdl/apc_chk.sv */
// Port-level checker for the amicable pair checker, bound to the top level.
module apc_chk
    import apc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_W      = ((2 * VALUE_BITS + 7) / 8) * 8
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_s_tvalid,
    input logic            o_s_tready,
    input logic [IN_W-1:0] i_s_tdata,
    input logic            o_m_tvalid,
    input logic            i_m_tready,
    input logic [7:0]      o_m_tdata
);

    // busy after taking a word: no second word next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after accept");

    // a new result shows up exactly when the sequencer returns to idle
    a_result_with_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result appeared while busy");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'd0))
        else $error("output padding not zero");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("reset did not clear output valid");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled word changed");

endmodule

bind amicable_pair_check apc_chk #(.VALUE_BITS(VALUE_BITS)) u_apc_chk (.*);

/* test/tb_amicable_pair_check.sv */
// Testbench for amicable_pair_check: directed table, then random words, checked in order.
`timescale 1ns / 1ps

module tb_amicable_pair_check;
    import apc_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int IN_W        = ((2 * VB + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 100;
    localparam int HOLD_CYCLES  = 2500;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        bit            typed;
        bit            verdict;
    } drill_t;

    typedef struct packed {
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        bit            verdict;
    } pending_t;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_tvalid;
    logic            o_s_tready;
    logic [IN_W-1:0] i_s_tdata;   // first_value, second_value
    logic            o_m_tvalid;
    logic            i_m_tready;
    logic [7:0]      o_m_tdata;   // is_pair

    pending_t verdict_q[$];
    drill_t   drills[$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  hits_seen       = 0;
    int  directed_sent   = 0;
    int  random_sent     = 0;
    int  input_stalls    = 0;
    int  holds_requested = 0;
    int  holds_served    = 0;
    bit  calm            = 1'b0;

    amicable_pair_check #(.VALUE_BITS(VB)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(64'd60_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // sum of divisors of v below v itself; v >= 2
    function automatic longint unsigned aliquot_total(longint unsigned v);
        longint unsigned total;
        longint unsigned d;
        total = 0;
        for (d = 1; d * d <= v; d++) begin
            if (v % d == 0) begin
                total += d;
                if (v / d != d) total += v / d;
            end
        end
        return total - v;
    endfunction

    function automatic bit amicable_verdict(logic [VB-1:0] a, logic [VB-1:0] b);
        if (a < 2 || b < 2) return 1'b0;
        return (aliquot_total(b) == a) && (aliquot_total(a) == b);
    endfunction

    // amicable pairs and perfect numbers that fit in 16 bits
    function automatic void known_pair(int idx, output logic [VB-1:0] a,
                                       output logic [VB-1:0] b);
        case (idx)
            0:       begin a = 220;   b = 284;   end
            1:       begin a = 1184;  b = 1210;  end
            2:       begin a = 2620;  b = 2924;  end
            3:       begin a = 5020;  b = 5564;  end
            4:       begin a = 6232;  b = 6368;  end
            5:       begin a = 10744; b = 10856; end
            6:       begin a = 12285; b = 14595; end
            7:       begin a = 17296; b = 18416; end
            8:       begin a = 6;     b = 6;     end
            9:       begin a = 28;    b = 28;    end
            10:      begin a = 496;   b = 496;   end
            default: begin a = 8128;  b = 8128;  end
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic add_drill(int a, int b, bit typed, bit verdict);
        drill_t d;
        d.a = VB'(a);
        d.b = VB'(b);
        d.typed = typed;
        d.verdict = verdict;
        drills.push_back(d);
    endtask

    task automatic send_word(logic [VB-1:0] a, logic [VB-1:0] b, bit verdict);
        int gap;
        pending_t p;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        do begin
            @(posedge i_clk);
            if (!o_s_tready) input_stalls++;
        end while (!o_s_tready);
        p.a = a;
        p.b = b;
        p.verdict = verdict;
        verdict_q.push_back(p);
    endtask

    task automatic random_operands(bit quick, output logic [VB-1:0] a,
                                   output logic [VB-1:0] b);
        int r;
        logic [VB-1:0] t;
        r = $urandom_range(0, 99);
        if (quick) begin
            a = VB'($urandom_range(2, 63));
            b = VB'($urandom_range(2, 63));
        end else if (r < 25) begin
            known_pair($urandom_range(0, 11), a, b);
            if ($urandom_range(0, 1)) begin
                t = a; a = b; b = t;
            end
        end else if (r < 35) begin
            known_pair($urandom_range(0, 11), a, b);
            if ($urandom_range(0, 1)) a = a + VB'($urandom_range(1, 3));
            else                      b = b - VB'($urandom_range(1, 3));
        end else if (r < 60) begin
            a = VB'($urandom_range(2, 4095));
            b = VB'($urandom_range(2, 4095));
        end else if (r < 72) begin
            a = VB'($urandom_range(0, 63));
            b = VB'($urandom_range(0, 63));
        end else if (r < 90) begin
            a = VB'($urandom_range(0, 65535));
            b = VB'($urandom_range(0, 65535));
        end else begin
            a = VB'($urandom_range(0, 65535));
            b = VB'($urandom_range(0, 255));
        end
    endtask

    task automatic check_result();
        pending_t p;
        if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("result word 0x%02h with nothing outstanding",
                                    o_m_tdata));
            return;
        end
        p = verdict_q.pop_front();
        results_checked++;
        if (p.verdict) hits_seen++;
        if (o_m_tdata !== {7'd0, p.verdict})
            flag_mismatch($sformatf("a=%0d b=%0d is_pair word 0x%02h, want %0d",
                                    p.a, p.b, o_m_tdata, p.verdict));
    endtask

    // result side: check accepted words, drive ready with random stalls and a requested long hold
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_m_tvalid && i_m_tready) check_result();
                if (holds_served != holds_requested) begin
                    holds_served++;
                    stall_left = HOLD_CYCLES;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                    stall_left = idle_gap();
                end
            end
        end
    end

    // word side: directed table, then random words
    initial begin
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        bit            want;
        int            tail;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;

        add_drill(0,     0,     1, 0);
        add_drill(1,     1,     1, 0);
        add_drill(0,     220,   1, 0);
        add_drill(284,   1,     1, 0);
        add_drill(1,     2,     1, 0);
        add_drill(2,     2,     1, 0);
        add_drill(7,     7,     1, 0);
        add_drill(65521, 65521, 1, 0);
        add_drill(65535, 0,     1, 0);
        add_drill(0,     65535, 1, 0);
        add_drill(220,   284,   1, 1);
        add_drill(284,   220,   1, 1);
        add_drill(6,     6,     1, 1);
        add_drill(28,    28,    1, 1);
        add_drill(496,   496,   1, 1);
        add_drill(8128,  8128,  1, 1);
        add_drill(1184,  1210,  1, 1);
        add_drill(18416, 17296, 1, 1);
        add_drill(12285, 14595, 1, 1);
        add_drill(220,   220,   0, 0);
        add_drill(6,     28,    0, 0);
        add_drill(65535, 65535, 0, 0);
        add_drill(65534, 32768, 0, 0);
        add_drill(221,   284,   0, 0);

        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);
        if (o_m_tvalid !== 1'b0) flag_mismatch("output valid set after reset");

        foreach (drills[i]) begin
            want = drills[i].typed ? drills[i].verdict
                                   : amicable_verdict(drills[i].a, drills[i].b);
            send_word(drills[i].a, drills[i].b, want);
            directed_sent++;
        end

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 30) holds_requested++;
            if (k == 60) begin
                i_s_tvalid <= 1'b0;
                while (verdict_q.size() != 0) @(posedge i_clk);
            end
            calm = (k >= 70 && k < 85);
            random_operands(k >= 30 && k < 38, a, b);
            send_word(a, b, amicable_verdict(a, b));
            random_sent++;
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        for (tail = 0; tail < SETTLE_CYCLES; tail++) @(posedge i_clk);

        $display("covered %0d directed and %0d random words, %0d checked, %0d pairs",
                 directed_sent, random_sent, results_checked, hits_seen);
        $display("input held off for %0d cycles, including a long result-side hold-off",
                 input_stalls);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/apc_pkg.sv
hdl/apc_div.sv
hdl/amicable_pair_check.sv
hdl/apc_chk.sv
test/tb_amicable_pair_check.sv
